// ----- design/assert_macros.svh -----
// Assertion macros shared by the timer pool modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mtp_pkg.sv -----
// Types and constants of the timer pool.
package mtp_pkg;

  // Timer modes
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_MULTI  = 2'd1;
  localparam logic [1:0] MODE_REPEAT = 2'd2;
  localparam logic [1:0] MODE_REFUSE = 2'd3;

  // Operations
  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] period;
    logic [1:0]  mode;
    logic [31:0] shot_count;
    logic        notify;
    logic [63:0] now;
  } in_word_t;

  typedef struct packed {
    logic        create_ok;
    logic [2:0]  handle;
    logic [7:0]  fired_mask;
    logic [7:0]  active_mask;
    logic        compare_valid;
    logic [63:0] compare_value;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL_LO,
    ST_ADD_LO,
    ST_MUL_HI,
    ST_ADD_HI,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    MAC_HOLD,
    MAC_MUL_LO,
    MAC_ADD_LO,
    MAC_MUL_HI,
    MAC_ADD_HI
  } mac_op_t;

  // Slot write controls
  typedef struct packed {
    logic start;
    logic set_count;
    logic set_shots;
    logic stop;
  } slot_wr_t;

endpackage

// ----- design/mtp_slot_bank.sv -----
// Per-slot timer state with one indexed read and one indexed write.
`include "assert_macros.svh"

module mtp_slot_bank
  import mtp_pkg::*;
#(
  parameter int TIMERS      = 8,
  parameter int COUNT_WIDTH = 32,
  localparam int IW         = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IW-1:0]          idx,
  input  slot_wr_t               wr,
  input  logic [1:0]             wr_mode,
  input  logic                   wr_notify,
  input  logic [COUNT_WIDTH-1:0] wr_reload,
  input  logic [COUNT_WIDTH-1:0] wr_count,
  input  logic [COUNT_WIDTH-1:0] wr_shots,
  output logic [TIMERS-1:0]      running,
  output logic [1:0]             rd_mode,
  output logic                   rd_notify,
  output logic [COUNT_WIDTH-1:0] rd_reload,
  output logic [COUNT_WIDTH-1:0] rd_count,
  output logic [COUNT_WIDTH-1:0] rd_shots
);

  logic [1:0]             mode_q   [TIMERS];
  logic                   notify_q [TIMERS];
  logic [COUNT_WIDTH-1:0] reload_q [TIMERS];
  logic [COUNT_WIDTH-1:0] count_q  [TIMERS];
  logic [COUNT_WIDTH-1:0] shots_q  [TIMERS];

  // Running flags: cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
    end else if (wr.start) begin
      running[idx] <= 1'b1;
    end else if (wr.stop) begin
      running[idx] <= 1'b0;
    end
  end

  // Slot payload
  always_ff @(posedge clk) begin
    if (wr.start) begin
      mode_q[idx]   <= wr_mode;
      notify_q[idx] <= wr_notify;
      reload_q[idx] <= wr_reload;
      count_q[idx]  <= wr_reload;
      shots_q[idx]  <= wr_shots;
    end else begin
      if (wr.set_count) begin
        count_q[idx] <= wr_count;
      end
      if (wr.set_shots) begin
        shots_q[idx] <= wr_shots;
      end
    end
  end

  // Read the walked slot
  assign rd_mode   = mode_q[idx];
  assign rd_notify = notify_q[idx];
  assign rd_reload = reload_q[idx];
  assign rd_count  = count_q[idx];
  assign rd_shots  = shots_q[idx];

  `ASSERT_IMPL(a_start_free, wr.start, !running[idx], "create loaded a running slot")
  `ASSERT_IMPL(a_one_write, wr.start, !wr.stop && !wr.set_count, "conflicting slot writes")

endmodule

// ----- design/mtp_mac.sv -----
// Two-pass 32x32 multiply and accumulate for the compare value.
module mtp_mac
  import mtp_pkg::*;
(
  input  logic        clk,
  input  mac_op_t     op,
  input  logic [63:0] now,
  input  logic [63:0] factor,
  input  logic [31:0] scale,
  output logic [63:0] acc
);

  logic [31:0] mul_a;
  logic [63:0] prod;

  // Pick the factor half for this pass
  assign mul_a = (op == MAC_MUL_HI) ? factor[63:32] : factor[31:0];

  // Multiply, then add in the following cycle
  always_ff @(posedge clk) begin
    unique case (op)
      MAC_MUL_LO, MAC_MUL_HI: prod <= mul_a * scale;
      MAC_ADD_LO:             acc  <= now + prod;
      MAC_ADD_HI:             acc  <= acc + {prod[31:0], 32'd0};
      default: ;
    endcase
  end

endmodule

// ----- design/multi_timer_pool_top.sv -----
// Top level of the timer pool: sequencer, slot walk and result register.
//
// A pool of TIMERS countdown timers. Each word is either a create or a tick.
// The sequencer walks the slots one per cycle through a shared decrement and
// compare unit. A create then goes to the finish state; a tick first runs
// two multiply and two add passes of one 32x32 multiplier for now +
// soonest * tick_scale. The result register can then wait on out_ready.
// in_ready is low from acceptance until the result is loaded into the
// output register. A write of zero to the tick scale is ignored.
`include "assert_macros.svh"

module multi_timer_pool_top
  import mtp_pkg::*;
#(
  parameter int TIMERS      = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TIMERS - 1);

  state_t                 state, state_next;
  in_word_t               item;
  logic [31:0]            tick_scale;
  logic [IW-1:0]          idx;
  logic                   create_valid;
  logic                   taken;
  logic [2:0]             handle;
  logic                   found;
  logic [COUNT_WIDTH-1:0] soonest;
  logic [TIMERS-1:0]      fired;
  mac_op_t                mac_op;

  slot_wr_t               wr;
  logic [COUNT_WIDTH-1:0] wr_count, wr_shots;
  logic [TIMERS-1:0]      running;
  logic [1:0]             rd_mode;
  logic                   rd_notify;
  logic [COUNT_WIDTH-1:0] rd_reload, rd_count, rd_shots;
  logic [63:0]            acc;

  logic [COUNT_WIDTH-1:0] period_m, shots_m, dec, sdec, cand;
  logic                   run, keep, fire;

  assign period_m = COUNT_WIDTH'(item.period);
  assign shots_m  = COUNT_WIDTH'(item.shot_count);

  // Tick scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_scale <= 32'd1;
    end else if (cfg_we && cfg_wdata != 32'd0) begin
      tick_scale <= cfg_wdata;
    end
  end

  // Shared step unit for the walked slot
  always_comb begin
    run      = running[idx];
    dec      = rd_count - COUNT_WIDTH'(1);
    sdec     = rd_shots - COUNT_WIDTH'(1);
    wr       = '0;
    wr_count = dec;
    wr_shots = shots_m;
    keep     = 1'b0;
    fire     = 1'b0;
    cand     = dec;
    if (state == ST_WALK) begin
      if (item.operation == OP_CREATE) begin
        wr.start = create_valid && !taken && !run;
      end else if (run) begin
        if (dec != '0) begin
          wr.set_count = 1'b1;
          keep         = 1'b1;
        end else begin
          fire = rd_notify;
          case (rd_mode)
            MODE_MULTI: begin
              if (sdec == '0) begin
                wr.stop = 1'b1;
              end else begin
                wr.set_count = 1'b1;
                wr.set_shots = 1'b1;
                wr_count     = rd_reload;
                wr_shots     = sdec;
                cand         = rd_reload;
                keep         = 1'b1;
              end
            end
            MODE_REPEAT: begin
              wr.set_count = 1'b1;
              wr_count     = rd_reload;
              cand         = rd_reload;
              keep         = 1'b1;
            end
            default: wr.stop = 1'b1;
          endcase
        end
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier passes
  always_comb begin
    state_next = state;
    mac_op     = MAC_HOLD;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (idx == LAST_IDX) begin
          state_next = (item.operation == OP_TICK) ? ST_MUL_LO : ST_FINISH;
        end
      end
      ST_MUL_LO: begin
        mac_op     = MAC_MUL_LO;
        state_next = ST_ADD_LO;
      end
      ST_ADD_LO: begin
        mac_op     = MAC_ADD_LO;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        mac_op     = MAC_MUL_HI;
        state_next = ST_ADD_HI;
      end
      ST_ADD_HI: begin
        mac_op     = MAC_ADD_HI;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Capture the word and track the walk
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item         <= in_data;
      idx          <= '0;
      taken        <= 1'b0;
      handle       <= 3'd0;
      found        <= 1'b0;
      fired        <= '0;
      create_valid <= (COUNT_WIDTH'(in_data.period) != '0) && (in_data.mode != MODE_REFUSE)
                      && !(in_data.mode == MODE_MULTI && COUNT_WIDTH'(in_data.shot_count) == '0);
    end else if (state == ST_WALK) begin
      idx <= idx + IW'(1);
      if (wr.start) begin
        taken  <= 1'b1;
        handle <= 3'(idx);
      end
      if (fire) begin
        fired[idx] <= 1'b1;
      end
      if (keep && (!found || cand < soonest)) begin
        soonest <= cand;
        found   <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!out_valid || out_ready)) begin
      out_data.active_mask <= 8'(running);
      if (item.operation == OP_CREATE) begin
        out_data.create_ok     <= taken;
        out_data.handle        <= handle;
        out_data.fired_mask    <= 8'd0;
        out_data.compare_valid <= 1'b0;
        out_data.compare_value <= 64'd0;
      end else begin
        out_data.create_ok     <= 1'b0;
        out_data.handle        <= 3'd0;
        out_data.fired_mask    <= 8'(fired);
        out_data.compare_valid <= found;
        out_data.compare_value <= found ? acc : 64'd0;
      end
    end
  end

  mtp_slot_bank #(
    .TIMERS      (TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_bank (
    .clk       (clk),
    .rst       (rst),
    .idx       (idx),
    .wr        (wr),
    .wr_mode   (item.mode),
    .wr_notify (item.notify),
    .wr_reload (period_m),
    .wr_count  (wr_count),
    .wr_shots  (wr_shots),
    .running   (running),
    .rd_mode   (rd_mode),
    .rd_notify (rd_notify),
    .rd_reload (rd_reload),
    .rd_count  (rd_count),
    .rd_shots  (rd_shots)
  );

  mtp_mac u_mac (
    .clk    (clk),
    .op     (mac_op),
    .now    (item.now),
    .factor (64'(soonest)),
    .scale  (tick_scale),
    .acc    (acc)
  );

  `ASSERT_ALWAYS(a_scale_nonzero, tick_scale != 32'd0, "tick scale became zero")
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")
  `ASSERT_IMPL(a_create_no_compare, out_valid && out_data.create_ok,
               !out_data.compare_valid && out_data.fired_mask == 8'd0, "create has tick fields")
  `ASSERT_IMPL(a_walk_create_once, state == ST_WALK && taken, !wr.start,
               "second slot taken by one create")

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the timer pool: directed and random create/tick words, scoreboard checks.
`timescale 1ns / 100ps

module tb
  import mtp_pkg::*;
();

  localparam int TIMERS      = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_LASTING = 5;

  // Predicts every result word from the accepted words and checks what comes out.
  class pool_scoreboard;
    bit [31:0]  scale;
    bit         run [TIMERS];
    bit [1:0]   tmode [TIMERS];
    bit [31:0]  reload [TIMERS];
    bit [31:0]  count [TIMERS];
    bit [31:0]  shots [TIMERS];
    bit         notify_en [TIMERS];
    out_word_t  due_results [$];
    int mismatches, checked, started, refused, pool_full, ticks, expiries;

    function new();
      scale = 32'd1;
      foreach (run[i]) run[i] = 1'b0;
    endfunction

    // A zero scale leaves the old value in place.
    function void write_scale(bit [31:0] value);
      if (value != 0) scale = value;
    endfunction

    // Running slots that will not free up soon; keeps the pool from clogging.
    function int lasting_timers();
      int n;
      n = 0;
      foreach (run[i])
        if (run[i] && (tmode[i] == MODE_REPEAT || reload[i] > 64 ||
                       (tmode[i] == MODE_MULTI && shots[i] > 16)))
          n++;
      return n;
    endfunction

    function void note_word(in_word_t w);
      out_word_t  e;
      bit         found;
      bit [31:0]  soonest;
      e = '0;
      found = 1'b0;
      soonest = '0;
      if (w.operation == OP_CREATE) begin
        // refuse bad settings, else take the lowest free slot
        if (w.period == 0 || w.mode == MODE_REFUSE ||
            (w.mode == MODE_MULTI && w.shot_count == 0)) begin
          refused++;
        end else begin
          for (int i = 0; i < TIMERS; i++) begin
            if (!run[i] && !found) begin
              run[i] = 1'b1;
              tmode[i] = w.mode;
              reload[i] = w.period;
              count[i] = w.period;
              shots[i] = w.shot_count;
              notify_en[i] = w.notify;
              e.create_ok = 1'b1;
              e.handle = 3'(i);
              found = 1'b1;
            end
          end
          if (found) started++;
          else pool_full++;
        end
      end else begin
        // advance every running timer by one tick
        ticks++;
        for (int i = 0; i < TIMERS; i++) begin
          if (run[i]) begin
            count[i] = count[i] - 1;
            if (count[i] == 0) begin
              if (notify_en[i]) e.fired_mask[i] = 1'b1;
              case (tmode[i])
                MODE_SINGLE: run[i] = 1'b0;
                MODE_MULTI: begin
                  shots[i] = shots[i] - 1;
                  if (shots[i] == 0) run[i] = 1'b0;
                  else count[i] = reload[i];
                end
                MODE_REPEAT: count[i] = reload[i];
                default: run[i] = 1'b0;
              endcase
            end
          end
        end
        // soonest remaining count, lowest index on ties
        for (int i = 0; i < TIMERS; i++) begin
          if (run[i] && (!found || count[i] < soonest)) begin
            soonest = count[i];
            found = 1'b1;
          end
        end
        if (found) begin
          e.compare_valid = 1'b1;
          e.compare_value = w.now + 64'(soonest) * 64'(scale);
        end
        expiries += $countones(e.fired_mask);
      end
      foreach (run[i]) e.active_mask[i] = run[i];
      due_results.push_back(e);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: %s expected %h, got %h", checked, field, want, got);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word %h arrived with nothing pending", got);
        return;
      end
      e = due_results.pop_front();
      checked++;
      compare_field("create_ok", 64'(e.create_ok), 64'(got.create_ok));
      compare_field("handle", 64'(e.handle), 64'(got.handle));
      compare_field("fired_mask", 64'(e.fired_mask), 64'(got.fired_mask));
      compare_field("active_mask", 64'(e.active_mask), 64'(got.active_mask));
      compare_field("compare_valid", 64'(e.compare_valid), 64'(got.compare_valid));
      compare_field("compare_value", e.compare_value, got.compare_value);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  pool_scoreboard board = new();
  int cycle_count = 0;

  multi_timer_pool_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               board.due_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_word(in_data);
      if (out_valid && out_ready) board.check_word(out_data);
    end
  end

  // Receiver: stall rate changes per window, with two long hold-offs
  initial begin
    int window, stall_pct, next_hold;
    window = 0;
    stall_pct = 0;
    next_hold = 200;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (board.checked >= next_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        next_hold = (next_hold == 200) ? 700 : 32'h7FFF_FFFF;
      end else begin
        if (window == 0) begin
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 25;
            default: stall_pct = 60;
          endcase
          window = $urandom_range(20, 100);
        end
        window--;
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic in_word_t create_word(logic [31:0] period, logic [1:0] mode,
                                           logic [31:0] shot_count, logic notify);
    in_word_t w;
    w = '0;
    w.operation = OP_CREATE;
    w.period = period;
    w.mode = mode;
    w.shot_count = shot_count;
    w.notify = notify;
    return w;
  endfunction

  function automatic in_word_t tick_word(logic [63:0] now);
    in_word_t w;
    w = '0;
    w.operation = OP_TICK;
    w.now = now;
    return w;
  endfunction

  // Mostly short well-formed timers and ticks; some refused creates and long timers
  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    w.operation = OP_CREATE;
    w.period = $urandom;
    w.mode = 2'($urandom);
    w.shot_count = $urandom;
    w.notify = 1'($urandom);
    w.now = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      w.operation = OP_TICK;
    end else if (pick < 58) begin
      case ($urandom_range(0, 2))
        0: w.period = '0;
        1: w.mode = MODE_REFUSE;
        default: begin
          w.mode = MODE_MULTI;
          w.shot_count = '0;
        end
      endcase
    end else if (board.lasting_timers() < MAX_LASTING && $urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          w.mode = MODE_SINGLE;
          if (w.period == 0) w.period = 32'd1;
        end
        1: begin
          w.mode = MODE_REPEAT;
          w.period = $urandom_range(1, 24);
        end
        default: begin
          w.mode = MODE_MULTI;
          w.period = $urandom_range(1, 24);
          w.shot_count = $urandom_range(17, 32'hFFFF_FFFF);
        end
      endcase
    end else begin
      w.period = $urandom_range(1, 24);
      if ($urandom_range(0, 2) == 0) begin
        w.mode = MODE_MULTI;
        w.shot_count = $urandom_range(1, 6);
      end else begin
        w.mode = MODE_SINGLE;
      end
    end
    return w;
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_word(in_word_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Build the word at the falling edge so it sees the state after the last acceptance
  task automatic send_random();
    in_word_t w;
    @(negedge clk);
    w = random_word();
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic run_random(int words);
    int sent, burst;
    sent = 0;
    while (sent < words) begin
      burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < words; i++) begin
        send_random();
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
    end
  endtask

  // Write the scale only once the pool has drained
  task automatic set_tick_scale(logic [31:0] value);
    idle_sender(1);
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (TIMERS + 8) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_scale(value);
  endtask

  initial begin
    in_word_t directed [$];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty pool, refused settings, one-tick expiry, wide values, ties, pool full
    directed.push_back(tick_word(64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(create_word(32'd0, MODE_SINGLE, 32'd1, 1'b1));
    directed.push_back(create_word(32'd5, MODE_REFUSE, 32'd1, 1'b1));
    directed.push_back(create_word(32'd5, MODE_MULTI, 32'd0, 1'b1));
    directed.push_back(create_word(32'd1, MODE_SINGLE, 32'd0, 1'b1));
    directed.push_back(tick_word(64'd0));
    directed.push_back(create_word(32'hFFFF_FFFF, MODE_SINGLE, 32'hFFFF_FFFF, 1'b0));
    directed.push_back(create_word(32'd7, MODE_REPEAT, 32'd0, 1'b1));
    directed.push_back(create_word(32'd2, MODE_MULTI, 32'd2, 1'b1));
    directed.push_back(create_word(32'd1, MODE_MULTI, 32'd3, 1'b1));
    directed.push_back(create_word(32'd3, MODE_SINGLE, 32'd0, 1'b0));
    directed.push_back(tick_word(64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(tick_word({$urandom, $urandom}));
    directed.push_back(create_word(32'd2, MODE_SINGLE, 32'hA5A5_A5A5, 1'b1));
    directed.push_back(create_word(32'd3, MODE_REPEAT, 32'h5A5A_5A5A, 1'b1));
    directed.push_back(create_word(32'd5, MODE_SINGLE, 32'd0, 1'b1));
    directed.push_back(create_word(32'd4, MODE_SINGLE, 32'd0, 1'b1));
    directed.push_back(tick_word(64'h8000_0000_0000_0000));
    directed.push_back(tick_word(64'h7FFF_FFFF_FFFF_FFFF));
    directed.push_back(tick_word({$urandom, $urandom}));
    directed.push_back(tick_word({$urandom, $urandom}));
    directed.push_back(tick_word({$urandom, $urandom}));
    directed.push_back(create_word(32'h8000_0000, MODE_SINGLE, 32'd0, 1'b1));
    directed.push_back(tick_word(64'h0000_0000_FFFF_FFFF));
    foreach (directed[i]) send_word(directed[i]);

    // Random phases across scale settings; zero write must be ignored
    set_tick_scale(32'hFFFF_FFFF);
    run_random(300);
    set_tick_scale(32'd0);
    run_random(250);
    set_tick_scale($urandom_range(2, 65535));
    run_random(250);
    set_tick_scale(32'd1);
    run_random(250);

    // Drain and let the pipeline settle
    idle_sender(1);
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (TIMERS + 10) @(posedge clk);

    $display("Ran %0d ticks and %0d creates (%0d started, %0d refused, %0d on a full pool)",
             board.ticks, board.started + board.refused + board.pool_full, board.started,
             board.refused, board.pool_full);
    $display("Saw %0d notified expiries; %0d results compared, %0d mismatches",
             board.expiries, board.checked, board.mismatches);
    if (board.mismatches == 0 && board.due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
